@@ sv/ttb_pkg.sv @@
package ttb_pkg;

    localparam int LIMIT_W   = 16;
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CH_NUM    = 7;
    localparam int CH_W      = 3;
    localparam int FLAG_NUM  = 6;
    localparam int PRESS_W   = 2;
    localparam int KIND_W    = 2;

    // Channel numbers.
    localparam logic [CH_W-1:0] CH_SELECT = 3'd0;
    localparam logic [CH_W-1:0] CH_MARK   = 3'd1;
    localparam logic [CH_W-1:0] CH_SEND   = 3'd2;
    localparam logic [CH_W-1:0] CH_REPLY  = 3'd3;
    localparam logic [CH_W-1:0] CH_SCAN   = 3'd4;
    localparam logic [CH_W-1:0] CH_BLINK  = 3'd5;
    localparam logic [CH_W-1:0] CH_PRESS  = 3'd6;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_ARM   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_ACK   = 2'd3
    } kind_t;

    typedef enum logic [PRESS_W-1:0] {
        PS_IDLE    = 2'd0,
        PS_PRESSED = 2'd1,
        PS_SHORT   = 2'd2,
        PS_LONG    = 2'd3
    } press_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SELECT = 3'd0,
        CFG_MARK   = 3'd1,
        CFG_SEND   = 3'd2,
        CFG_REPLY  = 3'd3,
        CFG_SCAN   = 3'd4,
        CFG_BLINK  = 3'd5,
        CFG_SHORT  = 3'd6,
        CFG_LONG   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] select_timeout;
        logic [LIMIT_W-1:0] mark_timeout;
        logic [LIMIT_W-1:0] send_delay;
        logic [LIMIT_W-1:0] reply_period;
        logic [LIMIT_W-1:0] scan_period;
        logic [LIMIT_W-1:0] blink_period;
        logic [LIMIT_W-1:0] short_press_ticks;
        logic [LIMIT_W-1:0] long_press_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        select_timeout:    16'd1000,
        mark_timeout:      16'd50,
        send_delay:        16'd10,
        reply_period:      16'd250,
        scan_period:       16'd2,
        blink_period:      16'd250,
        short_press_ticks: 16'd25,
        long_press_ticks:  16'd500
    };

    typedef struct packed {
        logic [FLAG_NUM-1:0] flags;
        press_t              press;
    } result_t;

endpackage

@@ sv/ttb_cfg.sv @@
module ttb_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [ttb_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ttb_pkg::LIMIT_W-1:0]   wr_data,
    output ttb_pkg::cfg_t                 cfg
);
    import ttb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_SELECT: cfg_next.select_timeout    = wr_data;
                CFG_MARK:   cfg_next.mark_timeout      = wr_data;
                CFG_SEND:   cfg_next.send_delay        = wr_data;
                CFG_REPLY:  cfg_next.reply_period      = wr_data;
                CFG_SCAN:   cfg_next.scan_period       = wr_data;
                CFG_BLINK:  cfg_next.blink_period      = wr_data;
                CFG_SHORT:  cfg_next.short_press_ticks = wr_data;
                CFG_LONG:   cfg_next.long_press_ticks  = wr_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/ttb_core.sv @@
module ttb_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  ttb_pkg::kind_t             kind,
    input  logic [ttb_pkg::CH_W-1:0]   channel,
    input  logic                       button_down,
    input  logic                       blink_active,
    input  ttb_pkg::cfg_t              cfg,
    output ttb_pkg::result_t           res_next,
    output ttb_pkg::result_t           res_cur
);
    import ttb_pkg::*;

    // Compare width covers both the counters and the 16-bit limits.
    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [COUNT_WIDTH-1:0] cnt_reg  [CH_NUM];
    logic [COUNT_WIDTH-1:0] cnt_next [CH_NUM];
    logic [COUNT_WIDTH-1:0] inc      [CH_NUM];
    logic [LIMIT_W-1:0]     lim      [FLAG_NUM];
    logic [FLAG_NUM-1:0]    flags_reg;
    logic [FLAG_NUM-1:0]    flags_next;
    press_t                 press_reg;
    press_t                 press_next;

    always_comb
    begin
        lim[0] = cfg.select_timeout;
        lim[1] = cfg.mark_timeout;
        lim[2] = cfg.send_delay;
        lim[3] = cfg.reply_period;
        lim[4] = cfg.scan_period;
        lim[5] = cfg.blink_period;
        for (int c = 0; c < CH_NUM; c++)
        begin
            inc[c] = cnt_reg[c] + COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        press_next = press_reg;
        if (accept)
        begin
            unique case (kind)
                KIND_TICK:
                begin
                    // One-shot timeouts count only while armed.
                    for (int c = 0; c < 3; c++)
                    begin
                        if (cnt_reg[c] != '0)
                        begin
                            if (CMP_W'(inc[c]) > CMP_W'(lim[c]))
                            begin
                                cnt_next[c]   = '0;
                                flags_next[c] = 1'b1;
                            end
                            else
                            begin
                                cnt_next[c] = inc[c];
                            end
                        end
                    end

                    if (CMP_W'(inc[CH_REPLY]) > CMP_W'(lim[CH_REPLY]))
                    begin
                        cnt_next[CH_REPLY]   = COUNT_WIDTH'(1);
                        flags_next[CH_REPLY] = 1'b1;
                    end
                    else
                    begin
                        cnt_next[CH_REPLY] = inc[CH_REPLY];
                    end

                    if (CMP_W'(inc[CH_SCAN]) >= CMP_W'(lim[CH_SCAN]))
                    begin
                        cnt_next[CH_SCAN]   = '0;
                        flags_next[CH_SCAN] = 1'b1;
                    end
                    else
                    begin
                        cnt_next[CH_SCAN] = inc[CH_SCAN];
                    end

                    if (CMP_W'(inc[CH_BLINK]) > CMP_W'(lim[CH_BLINK]))
                    begin
                        cnt_next[CH_BLINK] = '0;
                        if (blink_active)
                        begin
                            flags_next[CH_BLINK] = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next[CH_BLINK] = inc[CH_BLINK];
                    end

                    // Press classifier runs only while a press is being timed.
                    if (cnt_reg[CH_PRESS] != '0)
                    begin
                        cnt_next[CH_PRESS] = inc[CH_PRESS];
                        if (CMP_W'(inc[CH_PRESS]) > CMP_W'(cfg.long_press_ticks))
                        begin
                            press_next         = button_down ? PS_LONG : PS_IDLE;
                            cnt_next[CH_PRESS] = '0;
                        end
                        else if ((CMP_W'(inc[CH_PRESS]) > CMP_W'(cfg.short_press_ticks))
                                 && (press_reg == PS_IDLE))
                        begin
                            if (!button_down)
                            begin
                                press_next         = PS_SHORT;
                                cnt_next[CH_PRESS] = '0;
                            end
                            else
                            begin
                                press_next = PS_PRESSED;
                            end
                        end
                    end
                end
                KIND_ARM:
                begin
                    if (channel <= CH_PRESS)
                    begin
                        cnt_next[channel] = COUNT_WIDTH'(1);
                    end
                end
                KIND_CLEAR:
                begin
                    if (channel < CH_PRESS)
                    begin
                        flags_next[channel] = 1'b0;
                    end
                end
                KIND_ACK:
                begin
                    press_next = PS_IDLE;
                end
                default:
                begin
                    press_next = press_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CH_NUM; c++)
            begin
                cnt_reg[c] <= '0;
            end
            flags_reg <= '0;
            press_reg <= PS_IDLE;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flags_reg <= flags_next;
            press_reg <= press_next;
        end
    end

    assign res_next.flags = flags_next;
    assign res_next.press = press_next;
    assign res_cur.flags  = flags_reg;
    assign res_cur.press  = press_reg;

endmodule

@@ sv/ttb_out_buf.sv @@
module ttb_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  ttb_pkg::result_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output ttb_pkg::result_t rd_data
);
    import ttb_pkg::*;

    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    push;
    logic    pop;

    assign wr_ready = !skid_valid_reg;
    assign push     = wr_valid && wr_ready;
    assign pop      = main_valid_reg && rd_ready;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = wr_data;
                main_valid_next = push;
            end
        end
        else if (!main_valid_reg)
        begin
            main_next       = wr_data;
            main_valid_next = push;
        end
        else if (push)
        begin
            skid_next       = wr_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign rd_valid = main_valid_reg;
    assign rd_data  = main_reg;

endmodule

@@ sv/tick_timeout_bank_with_press_classifier.sv @@
// Bank of tick-driven timers with a button-press classifier. Each input word is a tick,
// an arm of one channel, a clear of one event flag or an acknowledge of the press state,
// and each one produces exactly one output word holding the event flags and the press
// state as they stand after that word. Channels 0 to 2 are one-shot timeouts that count
// only while armed, channels 3 to 5 are free-running periods, and channel 6 times a
// button press and grades it as pressed, short or long. The block takes one word per
// clock while the skid register is empty: the whole update of the counters, flags and
// press state is a single increment and compare per channel, done between the accepted
// word and the state registers, so the state is ready for the next word. The output word
// is registered and backed by a one-word skid register, so a stalled output does not
// stop the next input word from being taken. The user must write limits through the
// configuration port while no words are in flight; the block does not enforce this.
module tick_timeout_bank_with_press_classifier #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ttb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttb_pkg::LIMIT_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ttb_pkg::KIND_W-1:0]    kind,
    input  logic [ttb_pkg::CH_W-1:0]      channel,
    input  logic                          button_down,
    input  logic                          blink_active,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttb_pkg::FLAG_NUM-1:0]  event_flags,
    output logic [ttb_pkg::PRESS_W-1:0]   press_state
);
    import ttb_pkg::*;

    cfg_t    cfg;
    result_t res_next;
    result_t res_cur;
    result_t res_out;
    logic    in_accept;

    // A word is taken whenever the skid register has room.
    assign in_accept = in_valid && in_ready;

    ttb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ttb_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .kind         (kind_t'(kind)),
        .channel      (channel),
        .button_down  (button_down),
        .blink_active (blink_active),
        .cfg          (cfg),
        .res_next     (res_next),
        .res_cur      (res_cur)
    );

    // The output word is the state after the accepted word.
    ttb_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (res_next),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (res_out)
    );

    assign event_flags = res_out.flags;
    assign press_state = res_out.press;

    // A clear of a flagged channel leaves that flag low in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (kind_t'(kind) == KIND_CLEAR) && (channel < CH_PRESS))
        |=> !res_cur.flags[$past(channel)])
        else $error("flag still set after clear");

    // An acknowledge returns the press state to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (kind_t'(kind) == KIND_ACK)) |=> (res_cur.press == PS_IDLE))
        else $error("press state not idle after acknowledge");

    // Arm, clear and acknowledge words never raise a flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (kind_t'(kind) != KIND_TICK))
        |=> ((res_cur.flags & ~$past(res_cur.flags)) == '0))
        else $error("flag raised by a non-tick word");

    // Without an accepted word the state holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(res_cur))
        else $error("state changed without an input word");

endmodule

@@ sim/tb_tick_timeout_bank_with_press_classifier.sv @@
module tb_tick_timeout_bank_with_press_classifier;

    timeunit 1ns;
    timeprecision 1ps;

    import ttb_pkg::*;

    // Counter width of the instance, and of the shadow counters below.
    localparam int CNT_W = 16;

    // Channel code seven names no timer at all.
    localparam logic [CH_W-1:0] CH_SPARE = 3'd7;

    // Limit values used by the fixed phases.
    localparam logic [LIMIT_W-1:0] LIMIT_MIN  = 16'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_TOP  = 16'd65534;

    // Number of random configurations after the three fixed ones.
    localparam int RANDOM_PHASES = 7;

    // One row of the directed table. When typed is set the expected word is
    // the one written in the row; otherwise the predictor supplies it.
    typedef struct {
        kind_t             k;
        logic [CH_W-1:0]   ch;
        logic              btn;
        logic              blink;
        bit                typed;
        result_t           want;
    } stim_row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [LIMIT_W-1:0]     cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic [KIND_W-1:0]      kind         = '0;
    logic [CH_W-1:0]        channel      = '0;
    logic                   button_down  = 1'b0;
    logic                   blink_active = 1'b0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [FLAG_NUM-1:0]    event_flags;
    logic [PRESS_W-1:0]     press_state;

    // Expectation that travels with the payload of a directed row.
    bit                     typed_en     = 1'b0;
    result_t                typed_word   = '0;

    // Shadow of the timer bank: counters, flags, press grade and limits.
    logic [CNT_W-1:0]       count_sh [CH_NUM];
    logic [FLAG_NUM-1:0]    flags_sh;
    press_t                 press_sh;
    logic [LIMIT_W-1:0]     limit_sh [CFG_NUM];

    // Output words still owed by the block, oldest first.
    result_t                due_words [$];

    stim_row_t              rows [$];
    logic [LIMIT_W-1:0]     plan [CFG_NUM];

    int                     mismatches = 0;
    int                     words_out  = 0;
    int                     burst_left = 0;
    int                     ready_left = 0;
    int                     btn_left   = 0;
    logic                   btn_level  = 1'b0;
    logic                   blink_level = 1'b0;

    tick_timeout_bank_with_press_classifier #(
        .COUNT_WIDTH(CNT_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .channel      (channel),
        .button_down  (button_down),
        .blink_active (blink_active),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_flags  (event_flags),
        .press_state  (press_state)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one input word to the shadow state and returns the output word
    // that the block must produce for it.
    task automatic apply_timer_word(input kind_t k, input logic [CH_W-1:0] ch,
                                    input logic btn, input logic blink,
                                    output result_t res);
        logic [CNT_W-1:0] v;
        case (k)
            KIND_TICK:
            begin
                // One-shot timeouts count only while armed and disarm on expiry.
                for (int c = CH_SELECT; c <= CH_SEND; c++)
                begin
                    if (count_sh[c] != '0)
                    begin
                        count_sh[c] = count_sh[c] + 1'b1;
                        if (count_sh[c] > limit_sh[c])
                        begin
                            count_sh[c] = '0;
                            flags_sh[c] = 1'b1;
                        end
                    end
                end

                // The reply period restarts at one, not zero.
                count_sh[CH_REPLY] = count_sh[CH_REPLY] + 1'b1;
                if (count_sh[CH_REPLY] > limit_sh[CFG_REPLY])
                begin
                    count_sh[CH_REPLY] = CNT_W'(1);
                    flags_sh[CH_REPLY] = 1'b1;
                end

                // The scan period is the only one compared greater-or-equal.
                count_sh[CH_SCAN] = count_sh[CH_SCAN] + 1'b1;
                if (count_sh[CH_SCAN] >= limit_sh[CFG_SCAN])
                begin
                    count_sh[CH_SCAN] = '0;
                    flags_sh[CH_SCAN] = 1'b1;
                end

                // The blink period always wraps, but flags only while blinking.
                count_sh[CH_BLINK] = count_sh[CH_BLINK] + 1'b1;
                if (count_sh[CH_BLINK] > limit_sh[CFG_BLINK])
                begin
                    count_sh[CH_BLINK] = '0;
                    if (blink)
                        flags_sh[CH_BLINK] = 1'b1;
                end

                // Press grading: long beats short, and short is judged only from idle.
                if (count_sh[CH_PRESS] != '0)
                begin
                    v = count_sh[CH_PRESS] + 1'b1;
                    count_sh[CH_PRESS] = v;
                    if (v > limit_sh[CFG_LONG])
                    begin
                        press_sh = btn ? PS_LONG : PS_IDLE;
                        count_sh[CH_PRESS] = '0;
                    end
                    else if (v > limit_sh[CFG_SHORT] && press_sh == PS_IDLE)
                    begin
                        if (!btn)
                        begin
                            press_sh = PS_SHORT;
                            count_sh[CH_PRESS] = '0;
                        end
                        else
                        begin
                            press_sh = PS_PRESSED;
                        end
                    end
                end
            end
            KIND_ARM:
            begin
                if (ch < CH_NUM)
                    count_sh[ch] = CNT_W'(1);
            end
            KIND_CLEAR:
            begin
                if (ch < FLAG_NUM)
                    flags_sh[ch] = 1'b0;
            end
            default:
            begin
                press_sh = PS_IDLE;
            end
        endcase
        res.flags = flags_sh;
        res.press = press_sh;
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        // Keep the log readable if the block is badly broken.
        if (mismatches <= 100)
            $display("output word %0d: %s is %0h, expected %0h", words_out, field, got, want);
    endtask

    // Reset of the shadow state, then on every edge: limit writes, accepted input
    // words and accepted output words. All of these are sampled as they stood just
    // before the edge, since every input is driven by a nonblocking assignment.
    always @(posedge clk)
    begin : watch
        result_t predicted;
        result_t due;
        result_t seen;
        if (!rst_n)
        begin
            foreach (count_sh[i])
                count_sh[i] = '0;
            flags_sh = '0;
            press_sh = PS_IDLE;
            limit_sh[CFG_SELECT] = CFG_RESET.select_timeout;
            limit_sh[CFG_MARK]   = CFG_RESET.mark_timeout;
            limit_sh[CFG_SEND]   = CFG_RESET.send_delay;
            limit_sh[CFG_REPLY]  = CFG_RESET.reply_period;
            limit_sh[CFG_SCAN]   = CFG_RESET.scan_period;
            limit_sh[CFG_BLINK]  = CFG_RESET.blink_period;
            limit_sh[CFG_SHORT]  = CFG_RESET.short_press_ticks;
            limit_sh[CFG_LONG]   = CFG_RESET.long_press_ticks;
        end
        else
        begin
            if (cfg_wr_en)
                limit_sh[cfg_index] = cfg_data;

            if (in_valid && in_ready)
            begin
                apply_timer_word(kind_t'(kind), channel, button_down, blink_active,
                                 predicted);
                due_words.push_back(typed_en ? typed_word : predicted);
            end

            if (out_valid && out_ready)
            begin
                seen.flags = event_flags;
                seen.press = press_t'(press_state);
                if (due_words.size() == 0)
                begin
                    report_mismatch("word with nothing due", seen, 0);
                end
                else
                begin
                    due = due_words.pop_front();
                    if (seen.flags !== due.flags)
                        report_mismatch("event_flags", seen.flags, due.flags);
                    if (seen.press !== due.press)
                        report_mismatch("press_state", seen.press, due.press);
                end
                words_out++;
            end
        end
    end

    // The receiver follows its own pattern of ready runs and stalls, independent of
    // whether a word is on offer.
    always @(posedge clk)
    begin
        if (ready_left != 0)
        begin
            ready_left--;
        end
        else if ($urandom_range(0, 9) < 3)
        begin
            out_ready <= 1'b0;
            ready_left = $urandom_range(0, 6);
        end
        else
        begin
            out_ready <= 1'b1;
            ready_left = $urandom_range(0, 15);
        end
    end

    task automatic add_row(input kind_t k, input logic [CH_W-1:0] ch, input logic btn,
                           input logic blink, input bit typed,
                           input logic [FLAG_NUM-1:0] flags, input press_t press);
        stim_row_t r;
        r.k = k;
        r.ch = ch;
        r.btn = btn;
        r.blink = blink;
        r.typed = typed;
        r.want.flags = flags;
        r.want.press = press;
        rows.push_back(r);
    endtask

    // Offers one input word and returns at the edge where it is taken. The sender
    // runs in bursts; at the start of a new burst it may drop valid for a while.
    task automatic send_word(input kind_t k, input logic [CH_W-1:0] ch, input logic btn,
                             input logic blink, input bit typed, input result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid     <= 1'b1;
        kind         <= k;
        channel      <= ch;
        button_down  <= btn;
        blink_active <= blink;
        typed_en     <= typed;
        typed_word   <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Called at the edge where the last word was taken. Valid is dropped, and the queue
    // is looked at only after the monitor has queued that word.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes every limit register from the plan, one per cycle.
    task automatic program_limits();
        cfg_idx_t idx;
        for (int i = 0; i < CFG_NUM; i++)
        begin
            idx = cfg_idx_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= plan[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Random words, mostly ticks. The button is held and released in runs whose
    // length is on the scale of the press limits, so that presses get graded as
    // pressed, short and long; arms of the press channel are favored so that a
    // press is timed often. Arms, clears and acknowledges break into the presses.
    task automatic random_words(input int n, input int press_span);
        int pick;
        kind_t k;
        logic [CH_W-1:0] ch;
        logic btn;
        logic blink;
        for (int i = 0; i < n; i++)
        begin
            if (btn_left == 0)
            begin
                btn_level = ~btn_level;
                btn_left = $urandom_range(1, press_span);
            end
            btn_left--;
            if ($urandom_range(0, 15) == 0)
                blink_level = ~blink_level;

            pick = $urandom_range(0, 99);
            if (pick < 68)
                k = KIND_TICK;
            else if (pick < 80)
                k = KIND_ARM;
            else if (pick < 90)
                k = KIND_CLEAR;
            else
                k = KIND_ACK;

            ch = CH_W'($urandom_range(0, 7));
            if (k == KIND_ARM && $urandom_range(0, 9) < 4)
                ch = CH_PRESS;

            // Fields a kind ignores carry noise.
            btn   = (k == KIND_TICK) ? btn_level : 1'($urandom_range(0, 1));
            blink = (k == KIND_TICK) ? blink_level : 1'($urandom_range(0, 1));
            send_word(k, ch, btn, blink, 1'b0, '0);
        end
    endtask

    initial
    begin
        int span;
        int count;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, at the reset limits. Typed rows hold what is plain from
        // the reset state: nothing flagged until the scan period of two runs out,
        // and channel seven, or a clear of the press channel, changes nothing.
        add_row(KIND_ACK,   CH_SELECT, 1'b1, 1'b1, 1'b1, 6'b000000, PS_IDLE);
        add_row(KIND_CLEAR, CH_SPARE,  1'b0, 1'b0, 1'b1, 6'b000000, PS_IDLE);
        add_row(KIND_ARM,   CH_SPARE,  1'b1, 1'b1, 1'b1, 6'b000000, PS_IDLE);
        add_row(KIND_TICK,  CH_SELECT, 1'b0, 1'b0, 1'b1, 6'b000000, PS_IDLE);
        add_row(KIND_TICK,  CH_SPARE,  1'b0, 1'b1, 1'b1, 6'b010000, PS_IDLE);
        add_row(KIND_CLEAR, CH_SCAN,   1'b0, 1'b0, 1'b1, 6'b000000, PS_IDLE);
        add_row(KIND_CLEAR, CH_PRESS,  1'b1, 1'b0, 1'b1, 6'b000000, PS_IDLE);
        add_row(KIND_ARM,   CH_PRESS,  1'b0, 1'b1, 1'b1, 6'b000000, PS_IDLE);
        add_row(KIND_ARM,   CH_SELECT, 1'b0, 1'b0, 1'b0, '0, PS_IDLE);
        add_row(KIND_ARM,   CH_MARK,   1'b1, 1'b0, 1'b0, '0, PS_IDLE);
        add_row(KIND_ARM,   CH_SEND,   1'b0, 1'b1, 1'b0, '0, PS_IDLE);
        add_row(KIND_ARM,   CH_REPLY,  1'b0, 1'b0, 1'b0, '0, PS_IDLE);
        add_row(KIND_ARM,   CH_SCAN,   1'b1, 1'b1, 1'b0, '0, PS_IDLE);
        add_row(KIND_ARM,   CH_BLINK,  1'b0, 1'b0, 1'b0, '0, PS_IDLE);
        add_row(KIND_TICK,  CH_BLINK,  1'b1, 1'b1, 1'b0, '0, PS_IDLE);
        add_row(KIND_TICK,  CH_PRESS,  1'b1, 1'b0, 1'b0, '0, PS_IDLE);
        add_row(KIND_CLEAR, CH_SELECT, 1'b0, 1'b0, 1'b0, '0, PS_IDLE);
        add_row(KIND_CLEAR, CH_MARK,   1'b1, 1'b1, 1'b0, '0, PS_IDLE);
        add_row(KIND_CLEAR, CH_SEND,   1'b0, 1'b0, 1'b0, '0, PS_IDLE);
        add_row(KIND_CLEAR, CH_REPLY,  1'b0, 1'b1, 1'b0, '0, PS_IDLE);
        add_row(KIND_CLEAR, CH_BLINK,  1'b1, 1'b0, 1'b0, '0, PS_IDLE);
        add_row(KIND_ACK,   CH_SPARE,  1'b1, 1'b1, 1'b0, '0, PS_IDLE);
        add_row(KIND_TICK,  CH_SCAN,   1'b0, 1'b1, 1'b0, '0, PS_IDLE);

        foreach (rows[i])
            send_word(rows[i].k, rows[i].ch, rows[i].btn, rows[i].blink,
                      rows[i].typed, rows[i].want);
        settle();

        // Random phases. The first three use the smallest limits, zero limits
        // (scan flags every tick, the rest expire on the first counted tick) and
        // the largest limits; the rest mostly use small limits so that timers
        // expire often, with now and then an extreme value.
        for (int p = 0; p < 3 + RANDOM_PHASES; p++)
        begin
            count = 175;
            case (p)
                0:
                begin
                    foreach (plan[i])
                        plan[i] = LIMIT_MIN;
                    plan[CFG_BLINK] = '0;
                end
                1:
                begin
                    foreach (plan[i])
                        plan[i] = '0;
                end
                2:
                begin
                    foreach (plan[i])
                        plan[i] = LIMIT_TOP;
                    count = 100;
                end
                default:
                begin
                    foreach (plan[i])
                        plan[i] = LIMIT_W'($urandom_range(1, 40));
                    plan[CFG_LONG] = LIMIT_W'(plan[CFG_SHORT] + $urandom_range(0, 30));
                    if ($urandom_range(0, 3) == 0)
                        plan[CFG_BLINK] = '0;
                    foreach (plan[i])
                        if ($urandom_range(0, 9) == 0)
                            plan[i] = $urandom_range(0, 1) ? LIMIT_TOP : LIMIT_MIN;
                end
            endcase
            program_limits();
            span = (plan[CFG_LONG] > 52) ? 60 : plan[CFG_LONG] + 8;
            random_words(count, span);
            settle();
        end

        if (mismatches == 0)
            $display("tb_tick_timeout_bank_with_press_classifier: done, clean");
        else
            $display("tb_tick_timeout_bank_with_press_classifier: done, errors");
        $finish;
    end

    // A correct run takes well under half a millisecond; anything far beyond
    // that is a hang.
    initial
    begin
        #10_000_000;
        $display("tb_tick_timeout_bank_with_press_classifier: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ttb_pkg.sv
sv/ttb_cfg.sv
sv/ttb_core.sv
sv/ttb_out_buf.sv
sv/tick_timeout_bank_with_press_classifier.sv
sim/tb_tick_timeout_bank_with_press_classifier.sv
